// ----- rtl/ogf_pkg.sv -----
// package for the occupancy grid gap fill unit
// types and constants shared by controller, datapath and top level; no dependencies
package ogf_pkg;

  // grid side is fixed by the 7-bit coordinate fields
  localparam int GridSide = 128;
  localparam int CoordW   = $clog2(GridSide);

  localparam logic [7:0] CellWall    = 8'd0;
  localparam logic [7:0] CellUnknown = 8'd127;
  localparam logic [7:0] CellFree    = 8'd255;

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActRun   = 2'd1,
    ActRead  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegWallGap  = 2'd0,
    RegFloorGap = 2'd1,
    RegLongGap  = 2'd2
  } reg_index_e;

  typedef enum logic [1:0] {
    ModeWall  = 2'd0,
    ModeFloor = 2'd1,
    ModeLong  = 2'd2,
    ModeClear = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StPassInit,
    StCenterRd,
    StCenterChk,
    StScanRd,
    StScanChk,
    StFillWr,
    StNextDir,
    StNextCell,
    StPassEnd,
    StClrRd,
    StClrChk,
    StDone
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       pass_init;  // load scan start for the current mode
    logic       rd_center;  // read cell at scan position
    logic       rd_scan;    // read cell at center + step * dir
    logic       scan_init;  // step <- 1
    logic       scan_inc;   // step <- step + 1
    logic       fill_init;  // fill index <- 1, stop <- step
    logic       fill_wr;    // write fill cell, fill index ++
    logic       dir_next;   // advance direction
    logic       cell_next;  // advance scan position
    logic       clr_rd;     // read linear clear address
    logic       clr_wr;     // write wall at clear address
    logic       clr_next;
    logic       flag_clr;
    logic       flag_set;
    mode_e      mode;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic range_empty;
    logic center_hit;   // center cell triggers scans
    logic scan_stop;    // scanned cell ends the scan; a fill follows if stop_long
    logic scan_abort;   // long pass met a free cell
    logic scan_last;    // step equals the gap
    logic fill_last;    // fill index + 1 reaches stop
    logic stop_long;    // step > 1
    logic dir_last;
    logic cell_last;
    logic clr_hit;
    logic clr_last;
    logic flag;
  } dp_stat_t;

endpackage

// ----- rtl/ogf_ctrl.sv -----
// controller state machine of the gap fill unit
// sequences passes, scans and fills; uses ogf_pkg
module ogf_ctrl import ogf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mode_q  <= ModeWall;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.mode = mode_q;
    busy_o  = (state_q != StIdle);
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          mode_d  = ModeWall;
          state_d = StPassInit;
        end
      end
      StPassInit: begin
        cmd_o.pass_init = 1'b1;
        cmd_o.flag_clr  = 1'b1;
        state_d = StCenterRd;
      end
      StCenterRd: begin
        // range check reads empty_q, which is registered at pass init
        if (stat_i.range_empty) begin
          state_d = StPassEnd;
        end else begin
          cmd_o.rd_center = 1'b1;
          state_d = StCenterChk;
        end
      end
      StCenterChk: begin
        if (stat_i.center_hit) begin
          cmd_o.scan_init = 1'b1;
          state_d = StScanRd;
        end else begin
          state_d = StNextCell;
        end
      end
      StScanRd: begin
        cmd_o.rd_scan = 1'b1;
        state_d = StScanChk;
      end
      StScanChk: begin
        if (stat_i.scan_abort) begin
          state_d = StNextDir;
        end else if (stat_i.scan_stop) begin
          cmd_o.fill_init = 1'b1;
          if (stat_i.stop_long && mode_q != ModeLong) cmd_o.flag_set = 1'b1;
          state_d = stat_i.stop_long ? StFillWr : StNextDir;
        end else if (stat_i.scan_last) begin
          state_d = StNextDir;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = StScanRd;
        end
      end
      StFillWr: begin
        cmd_o.fill_wr = 1'b1;
        if (stat_i.fill_last) state_d = StNextDir;
      end
      StNextDir: begin
        if (stat_i.dir_last) begin
          state_d = StNextCell;
        end else begin
          cmd_o.dir_next  = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d = StScanRd;
        end
      end
      StNextCell: begin
        if (stat_i.cell_last) begin
          state_d = StPassEnd;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d = StCenterRd;
        end
      end
      StPassEnd: begin
        case (mode_q)
          ModeWall: begin
            if (!stat_i.flag) mode_d = ModeFloor;
            state_d = StPassInit;
          end
          ModeFloor: begin
            if (!stat_i.flag) mode_d = ModeLong;
            state_d = StPassInit;
          end
          ModeLong: begin
            mode_d  = ModeClear;
            cmd_o.pass_init = 1'b1;
            state_d = StClrRd;
          end
          default: state_d = StDone;
        endcase
      end
      StClrRd: begin
        cmd_o.clr_rd = 1'b1;
        state_d = StClrChk;
      end
      StClrChk: begin
        if (stat_i.clr_hit) cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StDone;
        end else begin
          cmd_o.clr_next = 1'b1;
          state_d = StClrRd;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ----- rtl/ogf_datapath.sv -----
// datapath of the gap fill unit: grid memory, scan counters and compares
// controlled by ogf_ctrl through dp_cmd_t; uses ogf_pkg
module ogf_datapath import ogf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [3:0]        wall_gap_i,
  input  logic [3:0]        floor_gap_i,
  input  logic [4:0]        long_gap_i,
  // host access while idle
  input  logic              host_wr_i,
  input  logic              host_rd_i,
  input  logic [CoordW-1:0] host_x_i,
  input  logic [CoordW-1:0] host_y_i,
  input  logic [7:0]        host_data_i,
  output logic [7:0]        rd_data_o,
  output dp_stat_t          stat_o
);

  localparam int Depth = GridSide * GridSide;
  localparam int AddrW = 2 * CoordW;
  localparam int SW    = CoordW + 2;  // signed coordinate width

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  logic [CoordW-1:0] x_q, y_q, lo_q, hi_q;
  logic              empty_q;
  logic [4:0]        step_q, stop_q, fidx_q;
  logic [1:0]        dir_q;
  logic [AddrW-1:0]  clr_q;
  logic              flag_q;

  logic [4:0] gap;
  always_comb begin
    case (cmd_i.mode)
      ModeWall:  gap = {1'b0, wall_gap_i};
      ModeFloor: gap = {1'b0, floor_gap_i};
      default:   gap = long_gap_i;
    endcase
  end

  // scan range: wall and long passes start at 0, floor pass at gap; all end below side - gap
  logic [CoordW:0] end_w, lo_w;
  assign end_w = (CoordW+1)'(GridSide) - (CoordW+1)'(gap);
  assign lo_w  = (cmd_i.mode == ModeFloor) ? (CoordW+1)'(gap) : '0;

  // offset coordinate for scan or fill index
  logic [4:0]         k;
  logic signed [SW-1:0] ox, oy;
  assign k = cmd_i.fill_wr ? fidx_q : step_q;
  always_comb begin
    ox = SW'(x_q);
    oy = SW'(y_q);
    case (dir_q)
      2'd0:    ox = SW'(x_q) + SW'(k);
      2'd1:    oy = SW'(y_q) + SW'(k);
      2'd2:    ox = SW'(x_q) - SW'(k);
      default: oy = SW'(y_q) - SW'(k);
    endcase
  end

  logic [AddrW-1:0] addr_c, addr_o, addr_h;
  assign addr_c = {y_q, x_q};
  assign addr_o = {oy[CoordW-1:0], ox[CoordW-1:0]};
  assign addr_h = {host_y_i, host_x_i};

  logic       we;
  logic [AddrW-1:0] wa;
  logic [7:0] wd;
  always_comb begin
    we = 1'b0;
    wa = addr_h;
    wd = host_data_i;
    if (host_wr_i) begin
      we = 1'b1;
    end else if (cmd_i.fill_wr) begin
      we = 1'b1;
      wa = addr_o;
      wd = (cmd_i.mode == ModeFloor) ? CellFree : CellWall;
    end else if (cmd_i.clr_wr) begin
      we = 1'b1;
      wa = clr_q;
      wd = CellWall;
    end
  end

  logic [AddrW-1:0] ra;
  always_comb begin
    ra = addr_h;
    if (cmd_i.rd_center)   ra = addr_c;
    else if (cmd_i.rd_scan) ra = addr_o;
    else if (cmd_i.clr_rd)  ra = clr_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (host_rd_i || cmd_i.rd_center || cmd_i.rd_scan || cmd_i.clr_rd) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; lo_q <= '0; hi_q <= '0; empty_q <= 1'b0;
      step_q <= '0; stop_q <= '0; fidx_q <= '0; dir_q <= '0;
      clr_q <= '0; flag_q <= 1'b0;
    end else begin
      if (cmd_i.pass_init) begin
        empty_q <= (gap == '0) || (lo_w >= end_w);
        lo_q    <= lo_w[CoordW-1:0];
        hi_q    <= CoordW'(end_w - 1'b1);
        x_q     <= lo_w[CoordW-1:0];
        y_q     <= lo_w[CoordW-1:0];
        clr_q   <= '0;
      end
      if (cmd_i.flag_clr) flag_q <= 1'b0;
      if (cmd_i.flag_set) flag_q <= 1'b1;
      if (cmd_i.scan_init) step_q <= 5'd1;
      if (cmd_i.scan_inc)  step_q <= step_q + 5'd1;
      if (cmd_i.fill_init) begin
        stop_q <= step_q;
        fidx_q <= 5'd1;
      end
      if (cmd_i.fill_wr) fidx_q <= fidx_q + 5'd1;
      if (cmd_i.dir_next) dir_q <= dir_q + 2'd1;
      if (cmd_i.cell_next) begin
        dir_q <= '0;
        if (y_q == hi_q) begin
          y_q <= lo_q;
          x_q <= x_q + 1'b1;
        end else begin
          y_q <= y_q + 1'b1;
        end
      end
      if (cmd_i.rd_center) dir_q <= '0;
      if (cmd_i.clr_next) clr_q <= clr_q + 1'b1;
    end
  end

  assign rd_data_o = rd_q;

  always_comb begin
    stat_o             = '0;
    stat_o.range_empty = empty_q;
    stat_o.center_hit  = (cmd_i.mode == ModeFloor) ? (rd_q == CellFree) : (rd_q == CellWall);
    stat_o.scan_abort  = (cmd_i.mode == ModeLong) && (rd_q == CellFree);
    stat_o.scan_stop   = (rd_q == CellWall) || ((cmd_i.mode == ModeFloor) && (rd_q == CellFree));
    stat_o.scan_last   = (step_q == gap);
    stat_o.stop_long   = (step_q > 5'd1);
    stat_o.fill_last   = (fidx_q + 5'd1 == stop_q);
    stat_o.dir_last    = (cmd_i.mode == ModeFloor) ? (dir_q == 2'd3) : (dir_q == 2'd1);
    stat_o.cell_last   = (x_q == hi_q) && (y_q == hi_q);
    stat_o.clr_hit     = (rd_q == CellUnknown);
    stat_o.clr_last    = (clr_q == AddrW'(Depth - 1));
    stat_o.flag        = flag_q;
  end

endmodule

// ----- rtl/occupancy_grid_gap_fill_unit.sv -----
// top level of the occupancy grid gap fill unit
// a read result passes the grid read register, then the output register; a write enters the grid on acceptance
// writes one per cycle while the input is not stalled; a read stalls the input until its result is
// delivered; a run sweeps the grid once per pass iteration, repeating wall and floor passes while
// fills are flagged, then turns unknown cells into walls; input stalls until delivery
// reset clears control state and sets the gap registers to 4, 8 and 12; grid contents stay undefined until written
module occupancy_grid_gap_fill_unit import ogf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [6:0] cell_x_i,
  input  logic [6:0] cell_y_i,
  input  logic [7:0] cell_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] cell_value_res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  logic [3:0] wall_gap_q, floor_gap_q;
  logic [4:0] long_gap_q;
  logic       out_valid_q, kind_q, rd_pend_q, rd_zero_q;
  logic [7:0] res_q;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy, done;
  logic [7:0] rd_data;

  logic acc, on_grid;
  assign in_stall_o  = busy || out_valid_q || rd_pend_q;
  assign acc         = in_valid_i && !in_stall_o;
  assign on_grid     = (32'(cell_x_i) < 32'(GridSide)) && (32'(cell_y_i) < 32'(GridSide));
  assign cfg_ready_o = 1'b1;

  logic [CoordW-1:0] hx, hy;
  assign hx = CoordW'(cell_x_i);
  assign hy = CoordW'(cell_y_i);

  ogf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i (acc && action_i == ActRun),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done)
  );

  ogf_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i       (cmd),
    .wall_gap_i  (wall_gap_q),
    .floor_gap_i (floor_gap_q),
    .long_gap_i  (long_gap_q),
    .host_wr_i   (acc && action_i == ActWrite && on_grid),
    .host_rd_i   (acc && action_i == ActRead),
    .host_x_i    (hx),
    .host_y_i    (hy),
    .host_data_i (cell_value_i),
    .rd_data_o   (rd_data),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_gap_q  <= 4'd4;
      floor_gap_q <= 4'd8;
      long_gap_q  <= 5'd12;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_zero_q   <= 1'b0;
      kind_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegWallGap:  wall_gap_q  <= cfg_data_i[3:0];
          RegFloorGap: floor_gap_q <= cfg_data_i[3:0];
          RegLongGap:  long_gap_q  <= cfg_data_i;
          default: ;
        endcase
      end
      rd_pend_q <= acc && action_i == ActRead;
      if (acc && action_i == ActRead) rd_zero_q <= !on_grid;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        kind_q      <= 1'b0;
        res_q       <= rd_zero_q ? 8'd0 : rd_data;
      end else if (done) begin
        out_valid_q <= 1'b1;
        kind_q      <= 1'b1;
        res_q       <= 8'd0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign cell_value_res_o = res_q;

endmodule
